FILE: src/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared widths, codes and types of the axis range colormap unit.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int COORD_W     = 32;
    localparam int LEVEL_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int AXIS_W      = 2;
    localparam int CMAP_W      = 3;
    localparam int CFG_DATA_W  = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_AXIS_SELECT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_MAP   = 1'd1;

    // item commands
    localparam logic CMD_MEASURE  = 1'b0;
    localparam logic CMD_COLORIZE = 1'b1;

    // axis codes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // colormap codes
    localparam logic [CMAP_W-1:0] CMAP_BLUE_RED      = 3'd0;
    localparam logic [CMAP_W-1:0] CMAP_GREEN_MAGENTA = 3'd1;
    localparam logic [CMAP_W-1:0] CMAP_WHITE_RED     = 3'd2;
    localparam logic [CMAP_W-1:0] CMAP_GREY_RED      = 3'd3;
    localparam logic [CMAP_W-1:0] CMAP_RAINBOW       = 3'd4;

    typedef enum logic [1:0] {
        LVL_ZERO,
        LVL_FULL,
        LVL_DIV
    } level_class_t;

    // one colorize item as the front part hands it over
    typedef struct packed {
        level_class_t       cls;
        logic [COORD_W-1:0] diff;   // c - min
        logic [COORD_W-1:0] span;   // max - min
    } entry_t;

endpackage

FILE: src/arc_queue.sv
// ----------------------------------------------------------------------------
// arc_queue
// Two-entry queue of classified colorize items between front and back.
// ----------------------------------------------------------------------------
module arc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  arc_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output arc_pkg::entry_t head,
    output logic            empty
);

    arc_pkg::entry_t                     mem_reg [arc_pkg::QUEUE_DEPTH];
    logic [arc_pkg::QPTR_W-1:0]          wr_ptr_reg;
    logic [arc_pkg::QPTR_W-1:0]          rd_ptr_reg;
    logic [arc_pkg::QCNT_W-1:0]          count_reg;

    assign full  = (count_reg == arc_pkg::QCNT_W'(arc_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= arc_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= arc_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= arc_pkg::QCNT_W'(count_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                count_reg <= arc_pkg::QCNT_W'(count_reg - 1'b1);
            end
        end
    end

endmodule

FILE: src/arc_front.sv
// ----------------------------------------------------------------------------
// arc_front
// Accepts items, tracks the min/max of the selected axis on measure beats and
// classifies colorize beats against the current range for the back part.
// ----------------------------------------------------------------------------
module arc_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [arc_pkg::AXIS_W-1:0]         axis_select,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic                               first,
    input  logic signed [arc_pkg::COORD_W-1:0] coord_x,
    input  logic signed [arc_pkg::COORD_W-1:0] coord_y,
    input  logic signed [arc_pkg::COORD_W-1:0] coord_z,
    input  logic                               queue_full,
    output logic                               push,
    output arc_pkg::entry_t                    push_data
);

    logic signed [arc_pkg::COORD_W-1:0] range_low_reg;
    logic signed [arc_pkg::COORD_W-1:0] range_high_reg;
    logic signed [arc_pkg::COORD_W-1:0] coord;
    logic                               accept;

    always_comb
    begin
        case (axis_select)
            arc_pkg::AXIS_X: coord = coord_x;
            arc_pkg::AXIS_Y: coord = coord_y;
            default:         coord = coord_z;
        endcase
    end

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (cmd == arc_pkg::CMD_COLORIZE);

    always_comb
    begin
        push_data.diff = arc_pkg::COORD_W'(coord - range_low_reg);
        push_data.span = arc_pkg::COORD_W'(range_high_reg - range_low_reg);
        if (range_low_reg == range_high_reg || coord <= range_low_reg)
        begin
            push_data.cls = arc_pkg::LVL_ZERO;
        end
        else if (coord >= range_high_reg)
        begin
            push_data.cls = arc_pkg::LVL_FULL;
        end
        else
        begin
            push_data.cls = arc_pkg::LVL_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end
        else if (accept && cmd == arc_pkg::CMD_MEASURE)
        begin
            if (first)
            begin
                range_low_reg  <= coord;
                range_high_reg <= coord;
            end
            else
            begin
                if (coord < range_low_reg)
                begin
                    range_low_reg <= coord;
                end
                if (coord > range_high_reg)
                begin
                    range_high_reg <= coord;
                end
            end
        end
    end

endmodule

FILE: src/arc_back.sv
// ----------------------------------------------------------------------------
// arc_back
// Takes classified items from the queue, divides for the level with a
// restoring divider one quotient bit per cycle, maps the level to RGB and
// holds the color in the output register.
// ----------------------------------------------------------------------------
module arc_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [arc_pkg::CMAP_W-1:0]       color_map,
    input  arc_pkg::entry_t                  head,
    input  logic                             empty,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [arc_pkg::CHAN_W-1:0]       red,
    output logic [arc_pkg::CHAN_W-1:0]       green,
    output logic [arc_pkg::CHAN_W-1:0]       blue
);

    localparam int NUM_W = arc_pkg::COORD_W + 9;
    localparam int DEN_W = arc_pkg::COORD_W + arc_pkg::LEVEL_W;
    localparam int CNT_W = $clog2(arc_pkg::LEVEL_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                          state_reg;
    logic [NUM_W-1:0]                num_reg;
    logic [DEN_W-1:0]                den_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [arc_pkg::LEVEL_W-1:0]     level_reg;
    logic                            out_valid_reg;
    logic [arc_pkg::CHAN_W-1:0]      red_reg;
    logic [arc_pkg::CHAN_W-1:0]      green_reg;
    logic [arc_pkg::CHAN_W-1:0]      blue_reg;

    logic [NUM_W-1:0]                head_num;
    logic                            ge;
    logic                            out_load;
    logic [arc_pkg::CHAN_W-1:0]      red_next;
    logic [arc_pkg::CHAN_W-1:0]      green_next;
    logic [arc_pkg::CHAN_W-1:0]      blue_next;
    logic [arc_pkg::CHAN_W-1:0]      dbl;

    // 510*d + r, the numerator of the rounded level
    assign head_num = {head.diff, 9'b0} - {8'b0, head.diff, 1'b0}
                    + NUM_W'(head.span);
    assign ge       = num_reg >= {1'b0, den_reg};
    assign pop      = (state_reg == ST_IDLE) && !empty;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // 2*v mod 256 serves both halves of the rainbow
    assign dbl = {level_reg[arc_pkg::LEVEL_W-2:0], 1'b0};

    always_comb
    begin
        case (color_map)
            arc_pkg::CMAP_BLUE_RED:
            begin
                red_next   = level_reg;
                green_next = '0;
                blue_next  = 8'd255 - level_reg;
            end
            arc_pkg::CMAP_GREEN_MAGENTA:
            begin
                red_next   = level_reg;
                green_next = 8'd255 - level_reg;
                blue_next  = level_reg;
            end
            arc_pkg::CMAP_WHITE_RED:
            begin
                red_next   = 8'd255;
                green_next = 8'd255 - level_reg;
                blue_next  = 8'd255 - level_reg;
            end
            arc_pkg::CMAP_GREY_RED:
            begin
                if (level_reg > 8'd128)
                begin
                    red_next   = 8'd255;
                    green_next = '0;
                    blue_next  = '0;
                end
                else
                begin
                    red_next   = 8'd128;
                    green_next = 8'd128;
                    blue_next  = 8'd128;
                end
            end
            default:
            begin
                red_next   = (level_reg > 8'd128) ? dbl : '0;
                green_next = (level_reg < 8'd128) ? dbl : 8'd255 - dbl;
                blue_next  = (level_reg < 8'd128) ? 8'd255 - dbl : '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_reg       <= '0;
            den_reg       <= '0;
            cnt_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                red_reg       <= red_next;
                green_reg     <= green_next;
                blue_reg      <= blue_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        case (head.cls)
                            arc_pkg::LVL_DIV:
                            begin
                                num_reg   <= head_num;
                                den_reg   <= {head.span, 8'b0};
                                cnt_reg   <= CNT_W'(arc_pkg::LEVEL_W - 1);
                                level_reg <= '0;
                                state_reg <= ST_DIV;
                            end
                            arc_pkg::LVL_FULL:
                            begin
                                level_reg <= '1;
                                state_reg <= ST_DONE;
                            end
                            default:
                            begin
                                level_reg <= '0;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_DIV:
                begin
                    level_reg <= {level_reg[arc_pkg::LEVEL_W-2:0], ge};
                    if (ge)
                    begin
                        num_reg <= num_reg - {1'b0, den_reg};
                    end
                    den_reg <= den_reg >> 1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg <= CNT_W'(cnt_reg - 1'b1);
                    end
                end
                ST_DONE:
                begin
                    // hold the level until the output register is free
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

FILE: src/axis_range_colormap_unit.sv
// ----------------------------------------------------------------------------
// axis_range_colormap_unit
// Min/max normalized pseudocolor map of one coordinate axis of a point cloud.
// ----------------------------------------------------------------------------
// Usage: send the cloud twice on the input channel (valid/ready). Measure
// beats (cmd 0) track the min and max of the selected axis; a beat with first
// set restarts the range from its own coordinate. Measure beats give no
// result and are taken one per cycle while the queue has room.
// Colorize beats (cmd 1) each give one red/green/blue beat on the output
// channel (valid/ready), in order. A colorize beat is classified against the
// range at its acceptance and parked in a two-entry queue; the back part then
// runs a restoring divider, one quotient bit per cycle, for the level; a point
// outside or on the range skips the divider. The back part takes its next item
// once the color is loaded; the queue takes colorize beats meanwhile. A
// stalled receiver holds the color in the output register; the back part
// finishes its next item and the queue fills, after which in_ready drops.
// Reset clears the range to zero, axis_select to y and color_map to rainbow.
// Write axis_select (index 0) and color_map (index 1) through cfg_write only
// while the block is idle.
// ----------------------------------------------------------------------------
module axis_range_colormap_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [arc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [arc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  cmd,
    input  logic                                  first,
    input  logic signed [arc_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [arc_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [arc_pkg::COORD_W-1:0]    coord_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [arc_pkg::CHAN_W-1:0]            red,
    output logic [arc_pkg::CHAN_W-1:0]            green,
    output logic [arc_pkg::CHAN_W-1:0]            blue
);

    logic [arc_pkg::AXIS_W-1:0] axis_select_reg;
    logic [arc_pkg::CMAP_W-1:0] color_map_reg;

    logic            push;
    arc_pkg::entry_t push_data;
    logic            queue_full;
    logic            pop;
    arc_pkg::entry_t head;
    logic            queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_select_reg <= arc_pkg::AXIS_Y;
            color_map_reg   <= arc_pkg::CMAP_RAINBOW;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                arc_pkg::REG_AXIS_SELECT: axis_select_reg <= cfg_data[arc_pkg::AXIS_W-1:0];
                arc_pkg::REG_COLOR_MAP:   color_map_reg   <= cfg_data[arc_pkg::CMAP_W-1:0];
                default:                  ;
            endcase
        end
    end

    arc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .axis_select (axis_select_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .first       (first),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .queue_full  (queue_full),
        .push        (push),
        .push_data   (push_data)
    );

    arc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    arc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .color_map (color_map_reg),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

FILE: dv/axis_range_colormap_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_range_colormap_unit_tb
// Self-checking bench: a table of measure and colorize beats, then random
// point clouds sent twice under every axis and colormap setting. Each color
// beat is compared against the table's color or an in-bench range tracker and colormap.
// ----------------------------------------------------------------------------
module axis_range_colormap_unit_tb;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 70;
    localparam int NUM_PHASES   = 8;
    localparam int DIR_ROWS     = 25;

    localparam logic signed [arc_pkg::COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [arc_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;

    typedef struct {
        logic                               cmd;
        logic                               first;
        logic signed [arc_pkg::COORD_W-1:0] x;
        logic signed [arc_pkg::COORD_W-1:0] y;
        logic signed [arc_pkg::COORD_W-1:0] z;
    } beat_t;

    typedef struct {
        logic [arc_pkg::CHAN_W-1:0] r;
        logic [arc_pkg::CHAN_W-1:0] g;
        logic [arc_pkg::CHAN_W-1:0] b;
    } rgb_t;

    typedef struct {
        logic                               cmd;
        logic                               first;
        logic signed [arc_pkg::COORD_W-1:0] x;
        logic signed [arc_pkg::COORD_W-1:0] y;
        logic signed [arc_pkg::COORD_W-1:0] z;
        bit                                 chk;
        logic [arc_pkg::CHAN_W-1:0]         r;
        logic [arc_pkg::CHAN_W-1:0]         g;
        logic [arc_pkg::CHAN_W-1:0]         b;
    } dir_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_write;
    logic [arc_pkg::CFG_INDEX_W-1:0]    cfg_index;
    logic [arc_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                               in_valid;
    logic                               in_ready;
    logic                               cmd;
    logic                               first;
    logic signed [arc_pkg::COORD_W-1:0] coord_x;
    logic signed [arc_pkg::COORD_W-1:0] coord_y;
    logic signed [arc_pkg::COORD_W-1:0] coord_z;
    logic                               out_valid;
    logic                               out_ready;
    logic [arc_pkg::CHAN_W-1:0]         red;
    logic [arc_pkg::CHAN_W-1:0]         green;
    logic [arc_pkg::CHAN_W-1:0]         blue;

    // bench copy of the range and the registers
    logic signed [arc_pkg::COORD_W-1:0] lo_bound;
    logic signed [arc_pkg::COORD_W-1:0] hi_bound;
    logic [arc_pkg::AXIS_W-1:0]         sel_axis;
    logic [arc_pkg::CMAP_W-1:0]         map_sel;

    rgb_t color_q [$];
    int   fail_cnt    = 0;
    int   stall_cnt   = 0;
    int   tx_idle_pct = 36;
    bit   press_req   = 1'b0;

    // rows walk y with the reset setting: axis y, rainbow
    dir_row_t dir_tab [DIR_ROWS] = '{
        // colorize before any measure: reset range gives level 0
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, 32'sh0005_0000, C_MIN, 1'b1, 8'd0, 8'd0, 8'd255},
        // measure with no first beat grows the range from zero
        '{arc_pkg::CMD_MEASURE,  1'b0, C_MIN, 32'sh0032_0000, C_MAX, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, 32'sh0, 32'sh0019_0000, -32'sh1, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, -32'sh1, 32'shFFFF_0000, 32'sh0, 1'b1, 8'd0, 8'd0, 8'd255},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, 32'sh0032_0000, C_MAX, 1'b1, 8'd254, 8'd1, 8'd0},
        // flat range: every level is 0
        '{arc_pkg::CMD_MEASURE,  1'b1, C_MIN, 32'sh0007_0000, C_MIN, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, 32'sh0007_0000, C_MIN, 1'b1, 8'd0, 8'd0, 8'd255},
        // first flag on a colorize beat is ignored
        '{arc_pkg::CMD_COLORIZE, 1'b1, C_MIN, 32'sh0064_0000, C_MAX, 1'b1, 8'd0, 8'd0, 8'd255},
        '{arc_pkg::CMD_MEASURE,  1'b1, 32'sh0, 32'shFF9C_0000, 32'sh0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_MEASURE,  1'b0, -32'sh1, 32'sh0064_0000, -32'sh1, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_MEASURE,  1'b0, C_MAX, 32'sh0000_8000, C_MIN, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MIN, 32'sh0, C_MAX, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, 32'shFF9C_0000, C_MIN, 1'b1, 8'd0, 8'd0, 8'd255},
        '{arc_pkg::CMD_COLORIZE, 1'b0, 32'sh0, 32'sh0064_0000, 32'sh0, 1'b1, 8'd254, 8'd1, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, -32'sh1, C_MAX, -32'sh1, 1'b1, 8'd254, 8'd1, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, C_MIN, C_MAX, 1'b1, 8'd0, 8'd0, 8'd255},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MIN, 32'shFF9C_0001, C_MIN, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, 32'sh0063_FFFF, C_MAX, 1'b0, 8'd0, 8'd0, 8'd0},
        // widest possible range
        '{arc_pkg::CMD_MEASURE,  1'b1, 32'sh0, C_MIN, 32'sh0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_MEASURE,  1'b0, C_MIN, C_MAX, C_MAX, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, -32'sh1, 32'sh0, C_MIN, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, C_MAX, 32'sh7FFF_FFFE, 32'sh0, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b1, C_MIN, 32'sh8000_0001, -32'sh1, 1'b0, 8'd0, 8'd0, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b0, 32'sh0, C_MAX, C_MAX, 1'b1, 8'd254, 8'd1, 8'd0},
        '{arc_pkg::CMD_COLORIZE, 1'b1, C_MAX, C_MIN, C_MIN, 1'b1, 8'd0, 8'd0, 8'd255}
    };

    logic [arc_pkg::AXIS_W-1:0] phase_axis [NUM_PHASES] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2,
                                                            2'd0, 2'd3, 2'd1};
    logic [arc_pkg::CMAP_W-1:0] phase_map  [NUM_PHASES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
                                                            3'd5, 3'd6, 3'd7};

    axis_range_colormap_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .first     (first),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10)
            $display("ERROR: %s", msg);
    endfunction

    function automatic logic [arc_pkg::LEVEL_W-1:0] norm_level(
        input logic signed [arc_pkg::COORD_W-1:0] c);
        longint d;
        longint r;
        longint q;
        if (lo_bound == hi_bound)
            return 8'd0;
        if (c <= lo_bound)
            return 8'd0;
        if (c >= hi_bound)
            return 8'd255;
        d = longint'(c) - longint'(lo_bound);
        r = longint'(hi_bound) - longint'(lo_bound);
        // round half up of d*255/r
        q = (d * 510 + r) / (2 * r);
        return q[arc_pkg::LEVEL_W-1:0];
    endfunction

    function automatic rgb_t map_color(input logic [arc_pkg::LEVEL_W-1:0] v);
        rgb_t o;
        int   vi;
        vi = int'(v);
        case (map_sel)
            arc_pkg::CMAP_BLUE_RED:
            begin
                o.r = v;
                o.g = 8'd0;
                o.b = 8'(255 - vi);
            end
            arc_pkg::CMAP_GREEN_MAGENTA:
            begin
                o.r = v;
                o.g = 8'(255 - vi);
                o.b = v;
            end
            arc_pkg::CMAP_WHITE_RED:
            begin
                o.r = 8'd255;
                o.g = 8'(255 - vi);
                o.b = 8'(255 - vi);
            end
            arc_pkg::CMAP_GREY_RED:
            begin
                o.r = (vi > 128) ? 8'd255 : 8'd128;
                o.g = (vi > 128) ? 8'd0 : 8'd128;
                o.b = (vi > 128) ? 8'd0 : 8'd128;
            end
            default:
            begin
                // rainbow, also for the unused codes
                o.r = (vi > 128) ? 8'((vi - 128) * 2) : 8'd0;
                o.g = (vi < 128) ? 8'(2 * vi) : 8'(255 - (vi - 128) * 2);
                o.b = (vi < 128) ? 8'(255 - 2 * vi) : 8'd0;
            end
        endcase
        return o;
    endfunction

    // advance the range on a measure beat, or color a colorize beat
    function automatic bit track_point(input beat_t b, output rgb_t col);
        logic signed [arc_pkg::COORD_W-1:0] c;
        case (sel_axis)
            arc_pkg::AXIS_X: c = b.x;
            arc_pkg::AXIS_Y: c = b.y;
            default:         c = b.z;
        endcase
        col = '{8'd0, 8'd0, 8'd0};
        if (b.cmd == arc_pkg::CMD_MEASURE)
        begin
            if (b.first)
            begin
                lo_bound = c;
                hi_bound = c;
            end
            else
            begin
                if (c < lo_bound)
                    lo_bound = c;
                if (c > hi_bound)
                    hi_bound = c;
            end
            return 1'b0;
        end
        col = map_color(norm_level(c));
        return 1'b1;
    endfunction

    function automatic logic signed [arc_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return (int'($urandom_range(0, 4000)) - 2000) <<< 12;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return 32'sh0;
                    default: return -32'sh1;
                endcase
            end
            default: return int'($urandom_range(0, 255)) - 128;
        endcase
    endfunction

    task automatic offer_beat(input beat_t b, input bit typed, input rgb_t typed_col);
        rgb_t col;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= b.cmd;
        first    <= b.first;
        coord_x  <= b.x;
        coord_y  <= b.y;
        coord_z  <= b.z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (track_point(b, col))
            color_q.push_back(typed ? typed_col : col);
    endtask

    // drop valid, wait for every color, then let measure beats drain
    task automatic settle();
        in_valid <= 1'b0;
        while (color_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [arc_pkg::AXIS_W-1:0] ax,
                                 input logic [arc_pkg::CMAP_W-1:0] cm);
        cfg_write <= 1'b1;
        cfg_index <= arc_pkg::REG_AXIS_SELECT;
        cfg_data  <= arc_pkg::CFG_DATA_W'(ax);
        @(posedge clk);
        cfg_index <= arc_pkg::REG_COLOR_MAP;
        cfg_data  <= arc_pkg::CFG_DATA_W'(cm);
        @(posedge clk);
        cfg_write <= 1'b0;
        sel_axis = ax;
        map_sel  = cm;
    endtask

    task automatic run_random(input int quota);
        beat_t pts [$];
        beat_t b;
        rgb_t  unused;
        int    sent;
        int    kind;
        int    n;
        sent   = 0;
        unused = '{8'd0, 8'd0, 8'd0};
        while (sent < quota)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 2)
            begin
                // noise beat
                b.cmd   = 1'($urandom_range(0, 1));
                b.first = 1'($urandom_range(0, 1));
                b.x     = rand_coord();
                b.y     = rand_coord();
                b.z     = rand_coord();
                offer_beat(b, 1'b0, unused);
                sent++;
            end
            else
            begin
                n = $urandom_range(1, 10);
                pts.delete();
                for (int i = 0; i < n; i++)
                begin
                    b.x = rand_coord();
                    b.y = rand_coord();
                    b.z = rand_coord();
                    if (kind == 2 && i > 0)
                        b = pts[0];
                    pts.push_back(b);
                end
                foreach (pts[i])
                begin
                    b       = pts[i];
                    b.cmd   = arc_pkg::CMD_MEASURE;
                    // a broken cloud gets its first flags at random
                    b.first = (kind == 3) ? 1'($urandom_range(0, 1)) : (i == 0);
                    offer_beat(b, 1'b0, unused);
                end
                foreach (pts[i])
                begin
                    b       = pts[i];
                    b.cmd   = arc_pkg::CMD_COLORIZE;
                    b.first = 1'($urandom_range(0, 1));
                    offer_beat(b, 1'b0, unused);
                end
                sent += 2 * n;
                repeat ($urandom_range(0, 2))
                begin
                    b.cmd   = arc_pkg::CMD_COLORIZE;
                    b.first = 1'($urandom_range(0, 1));
                    b.x     = rand_coord();
                    b.y     = rand_coord();
                    b.z     = rand_coord();
                    offer_beat(b, 1'b0, unused);
                    sent++;
                end
            end
        end
    endtask

    // output side: random back-pressure, one long hold-off, quiet stretches
    initial
    begin : rx_drive
        int seg;
        int cyc;
        bit held;
        seg  = 0;
        cyc  = 0;
        held = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (press_req && !held)
            begin
                // hold off while the sender keeps offering beats
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (seg % 5 == 3)
                    out_ready <= 1'b1;
                else
                    out_ready <= ($urandom_range(0, 99) >= 36);
                @(posedge clk);
                cyc++;
                if (cyc >= ((seg % 5 == 3) ? 400 : 150))
                begin
                    cyc = 0;
                    seg++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : color_check
        rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (color_q.size() == 0)
                note_fail($sformatf("unexpected color beat r=%0d g=%0d b=%0d",
                                    red, green, blue));
            else
            begin
                want = color_q.pop_front();
                if (red !== want.r || green !== want.g || blue !== want.b)
                    note_fail($sformatf("color exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                        want.r, want.g, want.b, red, green, blue));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin : main
        beat_t b;
        rgb_t  want;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= arc_pkg::REG_AXIS_SELECT;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        cmd       <= arc_pkg::CMD_MEASURE;
        first     <= 1'b0;
        coord_x   <= '0;
        coord_y   <= '0;
        coord_z   <= '0;
        lo_bound  = '0;
        hi_bound  = '0;
        sel_axis  = arc_pkg::AXIS_Y;
        map_sel   = arc_pkg::CMAP_RAINBOW;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            b.cmd   = dir_tab[i].cmd;
            b.first = dir_tab[i].first;
            b.x     = dir_tab[i].x;
            b.y     = dir_tab[i].y;
            b.z     = dir_tab[i].z;
            want.r  = dir_tab[i].r;
            want.g  = dir_tab[i].g;
            want.b  = dir_tab[i].b;
            offer_beat(b, dir_tab[i].chk, want);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            apply_setting(phase_axis[p], phase_map[p]);
            // one phase runs the sender flat out
            tx_idle_pct = (p == 3) ? 0 : 36;
            // the receiver holds off once while a phase is being sent
            press_req = (p == 1);
            run_random(PHASE_ITEMS);
        end

        settle();
        if (fail_cnt == 0 && color_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
